[design/bclst_pkg.sv]
// Shared types and constants for the bounded circular list store.
// Used by bclst_cell and bounded_circular_list_store_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bclst_pkg;

    // Number of list positions, one cell per position.
    localparam int CAPACITY = 16;
    // Width of the internal entry counter, able to hold CAPACITY itself.
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Width of the entry_count result field.
    localparam int COUNT_W  = 5;
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT = 2'd0,
        MODE_INS_BACK  = 2'd1,
        MODE_REMOVE    = 2'd2,
        MODE_SEARCH    = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FOUND    = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Write commands broadcast to every cell for one item.
    typedef struct packed {
        logic shift_in;   // take the left neighbor's entry (insert at front)
        logic append;     // the tail cell loads the operand
        logic remove;     // cells at or behind the first match take the right entry
    } t_cell_ctrl;

endpackage : bclst_pkg

`default_nettype wire

[design/bclst_cell.sv]
// One list position of the bounded circular list store: an entry register,
// its match compare and one link of the first-match chain. Uses bclst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bclst_cell (
    input  wire                                 i_clk,
    input  bclst_pkg::t_cell_ctrl               i_ctrl,
    input  wire logic signed [bclst_pkg::DATA_W-1:0] i_value,
    input  wire logic signed [bclst_pkg::DATA_W-1:0] i_left,
    input  wire logic signed [bclst_pkg::DATA_W-1:0] i_right,
    input  wire                                 i_valid,
    input  wire                                 i_tail,
    input  wire                                 i_seen,
    output logic                                o_seen,
    output logic signed [bclst_pkg::DATA_W-1:0]  o_entry
);
    import bclst_pkg::*;

    logic signed [DATA_W-1:0] r_entry;
    logic signed [DATA_W-1:0] n_entry;
    logic                     hit;

    assign hit    = i_valid && (r_entry == i_value);
    assign o_seen = i_seen || hit;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.shift_in) begin
            n_entry = i_left;
        end else if (i_ctrl.append && i_tail) begin
            n_entry = i_value;
        end else if (i_ctrl.remove && o_seen) begin
            // Everything from the first match backward closes the gap.
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule : bclst_cell

`default_nettype wire

[design/bounded_circular_list_store_top.sv]
// Top level of the bounded circular list store: a row of bclst_cell instances
// plus the entry counter and the result register. Uses bclst_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps an ordered list of up to CAPACITY signed 32-bit values and
// takes one command item in every clock cycle: insert at the front, append at
// the back, remove the first match from the front, or search. An item is taken
// when start is high; busy is always low, because every cell compares and
// shifts in parallel in the cycle of the item, so the list is up to date at
// the next edge. The result (status and entry count after the operation)
// appears on o_status and o_entry_count in the cycle after the item,
// marked by o_done for that single cycle. The receiver must take it then:
// there is no back pressure. The longest path is the 32-bit compare in a cell
// followed by the first-match chain that runs through all cells.
module bounded_circular_list_store_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire logic [bclst_pkg::MODE_W-1:0]          i_mode,
    input  wire logic signed [bclst_pkg::DATA_W-1:0]   i_value,
    output logic                                 o_done,
    output logic [bclst_pkg::STATUS_W-1:0]        o_status,
    output logic [bclst_pkg::COUNT_W-1:0]         o_entry_count
);
    import bclst_pkg::*;

    t_mode                     mode;
    t_cell_ctrl                ctrl;
    logic                      full;
    logic                      found;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_done;
    t_status                   r_status;
    t_status                   n_status;
    logic [COUNT_W-1:0]        r_entry_count;

    // Entry and first-match chain of every cell, plus the chain input.
    logic signed [DATA_W-1:0]  cell_entry [CAPACITY];
    logic                      seen [CAPACITY+1];

    assign mode = t_mode'(i_mode);
    assign full = (r_count == CNT_W'(CAPACITY));
    assign found = seen[CAPACITY];
    assign busy = 1'b0;

    // Command decode and the next count and status for the current item.
    always_comb begin
        ctrl     = '0;
        n_count  = r_count;
        n_status = ST_ABSENT;
        unique case (mode) inside
            MODE_INS_FRONT, MODE_INS_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status       = ST_INSERTED;
                    n_count        = r_count + CNT_W'(1);
                    ctrl.shift_in  = start && (mode == MODE_INS_FRONT);
                    ctrl.append    = start && (mode == MODE_INS_BACK);
                end
            end
            MODE_REMOVE: begin
                ctrl.remove = start;
                if (found) begin
                    n_status = ST_FOUND;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            MODE_SEARCH: begin
                n_status = found ? ST_FOUND : ST_ABSENT;
            end
            default: begin
                n_status = ST_ABSENT;
            end
        endcase
    end

    assign seen[0] = 1'b0;

    // The row of cells. The front cell takes the operand from its left side,
    // and the last cell keeps its own entry when the list closes a gap.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;

        if (g == 0) begin : g_front
            assign left = i_value;
        end else begin : g_inner_l
            assign left = cell_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_back
            assign right = cell_entry[g];
        end else begin : g_inner_r
            assign right = cell_entry[g+1];
        end

        bclst_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_value (i_value),
            .i_left  (left),
            .i_right (right),
            .i_valid (CNT_W'(g) < r_count),
            .i_tail  (CNT_W'(g) == r_count),
            .i_seen  (seen[g]),
            .o_seen  (seen[g+1]),
            .o_entry (cell_entry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= start;
            if (start) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload needs no reset: it is only looked at under o_done.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_status      <= n_status;
            r_entry_count <= COUNT_W'(n_count);
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

`ifndef SYNTHESIS
    // Every item gives exactly one result in the following cycle.
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_done)
        else $error("result strobe missing after an item");

    // The counter never runs past the capacity.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry counter above capacity");

    // A dropped insert is reported only with the list full.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    // A successful remove takes exactly one entry away.
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (mode == MODE_REMOVE) && found)
            |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove did not shorten the list by one");
`endif

endmodule : bounded_circular_list_store_top

`default_nettype wire

[sim/bclst_list_checker.sv]
// Checker for the bounded circular list store: predicts each command's status and
// entry count from the accepted items and compares them with the strobed results.
// Depends on bclst_pkg for the mode, status and width definitions.
`timescale 1ns / 1ps

module bclst_list_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic [bclst_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [bclst_pkg::DATA_W-1:0]  i_value,
    input  logic                                 o_done,
    input  logic [bclst_pkg::STATUS_W-1:0]       o_status,
    input  logic [bclst_pkg::COUNT_W-1:0]        o_entry_count,
    output int                                   fail_count,
    output int                                   outstanding
);

    import bclst_pkg::*;

    typedef struct packed {
        t_status                status;
        logic [COUNT_W-1:0]     entry_count;
    } t_list_reply;

    // Shadow copy of the list, front at index 0.
    logic [DATA_W-1:0] held_values[$];
    t_list_reply       replies_due[$];
    t_list_reply       oldest_reply;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("list checker @ %0t ns: %s", $realtime, what);
    endtask

    // Applies one command to the shadow list and queues the reply it should give.
    task automatic predict_list_op(input t_mode mode, input logic [DATA_W-1:0] operand);
        int          hit;
        t_list_reply reply;
        hit = -1;
        for (int k = 0; k < held_values.size(); k++) begin
            if (hit < 0 && held_values[k] == operand) begin
                hit = k;
            end
        end
        case (mode)
            MODE_INS_FRONT, MODE_INS_BACK: begin
                if (held_values.size() >= CAPACITY) begin
                    reply.status = ST_FULL;
                end else begin
                    if (mode == MODE_INS_FRONT) begin
                        held_values.push_front(operand);
                    end else begin
                        held_values.push_back(operand);
                    end
                    reply.status = ST_INSERTED;
                end
            end
            MODE_REMOVE: begin
                if (hit >= 0) begin
                    held_values.delete(hit);
                    reply.status = ST_FOUND;
                end else begin
                    reply.status = ST_ABSENT;
                end
            end
            default: begin
                reply.status = (hit >= 0) ? ST_FOUND : ST_ABSENT;
            end
        endcase
        reply.entry_count = COUNT_W'(held_values.size());
        replies_due.push_back(reply);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_values.delete();
            replies_due.delete();
        end else begin
            if (o_done) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("result strobe with no command outstanding");
                end else begin
                    oldest_reply = replies_due.pop_front();
                    if (o_status !== oldest_reply.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, oldest_reply.status));
                    end
                    if (o_entry_count !== oldest_reply.entry_count) begin
                        report_mismatch($sformatf("entry count %0d, expected %0d",
                                                  o_entry_count, oldest_reply.entry_count));
                    end
                end
            end
            if (start && !busy) begin
                predict_list_op(t_mode'(i_mode), i_value);
            end
        end
        outstanding <= replies_due.size();
    end

endmodule

[sim/tb_bounded_circular_list_store_top.sv]
// Testbench top for the bounded circular list store: clock, reset, command stimulus
// and the final verdict. Depends on bclst_pkg and bclst_list_checker.
`timescale 1ns / 1ps

module tb_bounded_circular_list_store_top;

    import bclst_pkg::*;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_ITEMS  = 1625;
    // The limit lies far beyond the length of the slowest correct run.
    localparam int CYCLE_LIMIT   = 200000;
    // Chance in percent that an item is preceded by an idle gap.
    localparam int IDLE_PCT      = 7;
    localparam int POOL_SIZE     = 8;
    localparam int PHASE_ITEMS   = 30;
    // The result is registered after its item; these extra cycles cover any slack.
    localparam int SETTLE_CYCLES = 4;

    // Kinds of random phase: mostly inserts, mostly removes, or an even mix.
    localparam int BIAS_FILL  = 0;
    localparam int BIAS_DRAIN = 1;
    localparam int BIAS_MIXED = 2;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [MODE_W-1:0]     i_mode;
    logic signed [DATA_W-1:0] i_value;
    logic                  o_done;
    logic [STATUS_W-1:0]   o_status;
    logic [COUNT_W-1:0]    o_entry_count;

    int                    fail_count;
    int                    outstanding;
    int                    cycle_count = 0;
    bit                    idling_on;
    int                    phase_bias;
    logic [DATA_W-1:0]     value_pool[POOL_SIZE];

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    bounded_circular_list_store_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    // The checker sees exactly what the block sees and keeps its own copy of the list.
    bclst_list_checker list_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL bounded_circular_list_store_top");
        $finish;
    end

    // Presents one command item and returns at the edge that accepts it. While idling
    // is enabled, start is sometimes dropped first, so that gaps can fall between
    // any two items. Back-to-back items keep start high without a dip.
    task automatic send_item(input t_mode mode, input logic [DATA_W-1:0] operand);
        if (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_mode  <= mode;
        i_value <= operand;
        do @(posedge i_clk); while (busy);
    endtask

    // Stops sending until the checker has seen every result it is waiting for. The
    // first wait lets the count from the last accepted item reach the checker output.
    task automatic hold_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // The pool holds the values of the current phase. Drawing most operands from a
    // small pool makes removes and searches hit entries in the list, and produces
    // duplicates, instead of almost always missing.
    task automatic refresh_pool();
        for (int k = 0; k < POOL_SIZE; k++) begin
            case ($urandom_range(0, 3))
                0:       value_pool[k] = $urandom;
                1:       value_pool[k] = DATA_W'($urandom_range(0, 15));
                2:       value_pool[k] = {DATA_W{1'b1}} - DATA_W'($urandom_range(0, 3));
                default: value_pool[k] = $urandom ^ {1'b1, {(DATA_W-1){1'b0}}};
            endcase
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return value_pool[$urandom_range(0, POOL_SIZE-1)];
        end else if (roll < 85) begin
            return $urandom;
        end
        case ($urandom_range(0, 3))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // The phase bias steers the list toward full, toward empty, or keeps it moving.
    function automatic t_mode pick_mode(input int bias);
        int roll;
        roll = $urandom_range(0, 99);
        case (bias)
            BIAS_FILL: begin
                if (roll < 35) return MODE_INS_FRONT;
                if (roll < 70) return MODE_INS_BACK;
                if (roll < 85) return MODE_REMOVE;
                return MODE_SEARCH;
            end
            BIAS_DRAIN: begin
                if (roll < 10) return MODE_INS_FRONT;
                if (roll < 20) return MODE_INS_BACK;
                if (roll < 75) return MODE_REMOVE;
                return MODE_SEARCH;
            end
            default: begin
                if (roll < 25) return MODE_INS_FRONT;
                if (roll < 50) return MODE_INS_BACK;
                if (roll < 75) return MODE_REMOVE;
                return MODE_SEARCH;
            end
        endcase
    endfunction

    initial begin
        start     <= 1'b0;
        i_mode    <= MODE_INS_FRONT;
        i_value   <= '0;
        i_rst_n   <= 1'b0;
        idling_on  = 1'b1;
        phase_bias = BIAS_MIXED;
        refresh_pool();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Removing and searching on an empty list must report the
        // value as absent with a count of zero.
        send_item(MODE_REMOVE, 32'h0000_0005);
        send_item(MODE_SEARCH, 32'h0000_0005);
        // Front inserts of the extreme values leave the list as all-ones, zero,
        // the largest positive and the most negative value, in that order.
        send_item(MODE_INS_FRONT, 32'h8000_0000);
        send_item(MODE_INS_FRONT, 32'h7FFF_FFFF);
        send_item(MODE_INS_FRONT, 32'h0000_0000);
        send_item(MODE_INS_FRONT, 32'hFFFF_FFFF);
        // A duplicate zero at the back; removing zero must take only the front one,
        // which leaves the one at the back for a later search or remove to find.
        send_item(MODE_INS_BACK, 32'h0000_0000);
        send_item(MODE_SEARCH, 32'h8000_0000);
        send_item(MODE_SEARCH, 32'h8000_0001);
        send_item(MODE_REMOVE, 32'h0000_0000);
        // Fill the list up to capacity with random entries; four are held already.
        for (int k = 0; k < CAPACITY - 4; k++) begin
            send_item(MODE_INS_BACK, $urandom);
        end
        // Inserts into a full list are dropped with the full status.
        send_item(MODE_INS_FRONT, 32'h1234_5678);
        send_item(MODE_INS_BACK, 32'h1234_5678);
        send_item(MODE_REMOVE, 32'h7FFF_FFFF);
        send_item(MODE_SEARCH, 32'h0000_0000);

        // Let the pipeline run dry once before the random part starts.
        hold_until_drained();

        // Random part. Each phase has its own bias and, now and then, a fresh pool.
        // A long stretch in the middle runs with no idle cycles at all.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                phase_bias = $urandom_range(BIAS_FILL, BIAS_MIXED);
                if ($urandom_range(0, 2) == 0) begin
                    refresh_pool();
                end
            end
            idling_on = !(n >= 600 && n < 900);
            if (n == 1200) begin
                hold_until_drained();
            end
            send_item(pick_mode(phase_bias), pick_value());
        end

        // Wait for the last results, then let the block run on for SETTLE_CYCLES in case
        // it strobes anything it should not.
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS bounded_circular_list_store_top");
        end else begin
            $display("FAIL bounded_circular_list_store_top");
        end
        $finish;
    end

endmodule

[bounded_circular_list_store_top.f]
design/bclst_pkg.sv
design/bclst_cell.sv
design/bounded_circular_list_store_top.sv
sim/bclst_list_checker.sv
sim/tb_bounded_circular_list_store_top.sv
